@@ rtl/uue_pkg.sv @@
// Shared constants and types for the uuencode line encoder.
package uue_pkg;

    localparam int LINE_BYTES = 45;
    localparam int ADDR_W     = $clog2(LINE_BYTES);
    localparam int CNT_W      = $clog2(LINE_BYTES + 1);

    localparam logic [6:0] CHAR_BIAS    = 7'd32;
    localparam logic [6:0] NEWLINE_CHAR = 7'd10;

    // Character to produce this cycle, issued only when the output register can load.
    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_LEN,
        EMIT_C0,
        EMIT_C1,
        EMIT_C2,
        EMIT_C3,
        EMIT_NL
    } t_emit;

    typedef struct packed {
        logic  accept;
        t_emit emit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic line_done;
        logic group_last;
    } t_status;

endpackage

@@ rtl/uuencode_line_encoder.sv @@
// A line's last byte sends the sequencer to S_LEN, which registers the length character.
// Throughput: one input byte per cycle while a line is collected; then a line of
// n bytes leaves as 2 + 4*ceil(n/3) characters, one per cycle while the output is not
// stalled, through the single character output port; input is held meanwhile.
// Reset (synchronous, active low) empties the line store count and the output register.
module uuencode_line_encoder import uue_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_final_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [6:0] o_out_char,
    output logic       o_line_end
);

    t_cmd    cmd;
    t_status status;

    uue_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    uue_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_char   (o_out_char),
        .o_line_end   (o_line_end)
    );

endmodule

@@ rtl/uue_ctrl.sv @@
// Sequencer: collects bytes, then walks the length, group and newline characters.
module uue_ctrl import uue_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IN,
        S_LEN,
        S_C0,
        S_C1,
        S_C2,
        S_C3,
        S_NL
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_stall = (r_state != S_IN);

    always_comb begin
        n_state      = r_state;
        o_cmd.accept = 1'b0;
        o_cmd.emit   = EMIT_NONE;
        unique case (r_state)
            S_IN: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.line_done) begin
                        n_state = S_LEN;
                    end
                end
            end
            S_LEN: begin
                if (i_status.out_free) begin
                    o_cmd.emit = EMIT_LEN;
                    n_state    = S_C0;
                end
            end
            S_C0: begin
                if (i_status.out_free) begin
                    o_cmd.emit = EMIT_C0;
                    n_state    = S_C1;
                end
            end
            S_C1: begin
                if (i_status.out_free) begin
                    o_cmd.emit = EMIT_C1;
                    n_state    = S_C2;
                end
            end
            S_C2: begin
                if (i_status.out_free) begin
                    o_cmd.emit = EMIT_C2;
                    n_state    = S_C3;
                end
            end
            S_C3: begin
                if (i_status.out_free) begin
                    o_cmd.emit = EMIT_C3;
                    n_state    = i_status.group_last ? S_NL : S_C0;
                end
            end
            S_NL: begin
                if (i_status.out_free) begin
                    o_cmd.emit = EMIT_NL;
                    n_state    = S_IN;
                end
            end
            default: n_state = S_IN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/uue_dp.sv @@
// Datapath: line store, byte counters, six-bit character forming and output register.
module uue_dp import uue_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    output t_status    o_status,
    input  logic [7:0] i_data_byte,
    input  logic       i_final_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [6:0] o_out_char,
    output logic       o_line_end
);

    logic [7:0]       mem [LINE_BYTES];
    logic [7:0]       r_rd_data;
    logic [CNT_W-1:0] r_fill;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_ptr;
    logic [CNT_W-1:0] n_ptr;
    logic [CNT_W-1:0] fill_inc;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]       r_prev;
    logic [7:0]       cur_byte;
    logic             r_out_valid;
    logic [6:0]       r_out_char;
    logic             r_out_end;
    logic [5:0]       field;

    assign fill_inc = r_fill + 1'b1;

    assign o_status.out_free   = !r_out_valid || !i_out_stall;
    assign o_status.line_done  = (fill_inc == CNT_W'(LINE_BYTES)) || i_final_byte;
    assign o_status.group_last = (r_ptr >= r_count);

    // Read pointer tracks the byte that r_rd_data holds; prefetch one ahead on advance.
    always_comb begin
        n_ptr = r_ptr;
        if (i_cmd.accept) begin
            n_ptr = '0;
        end else if (i_cmd.emit == EMIT_C0 || i_cmd.emit == EMIT_C1 ||
                     i_cmd.emit == EMIT_C2) begin
            n_ptr = r_ptr + 1'b1;
        end
    end

    assign rd_addr = (n_ptr < CNT_W'(LINE_BYTES)) ? n_ptr[ADDR_W-1:0] : '0;

    // Bytes past the count in a short group read as zero.
    assign cur_byte = (r_ptr < r_count) ? r_rd_data : 8'h00;

    always_comb begin
        field = 6'h00;
        unique case (i_cmd.emit)
            EMIT_C0: field = cur_byte[7:2];
            EMIT_C1: field = {r_prev[1:0], cur_byte[7:4]};
            EMIT_C2: field = {r_prev[3:0], cur_byte[7:6]};
            EMIT_C3: field = r_prev[5:0];
            default: field = 6'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            mem[r_fill[ADDR_W-1:0]] <= i_data_byte;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_count     <= '0;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_ptr <= n_ptr;
            if (i_cmd.accept) begin
                if (o_status.line_done) begin
                    r_fill  <= '0;
                    r_count <= fill_inc;
                end else begin
                    r_fill <= fill_inc;
                end
            end
            if (i_cmd.emit != EMIT_NONE) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit == EMIT_C0 || i_cmd.emit == EMIT_C1 || i_cmd.emit == EMIT_C2) begin
            r_prev <= cur_byte;
        end
        unique case (i_cmd.emit)
            EMIT_LEN: begin
                r_out_char <= CHAR_BIAS + 7'(r_count);
                r_out_end  <= 1'b0;
            end
            EMIT_C0, EMIT_C1, EMIT_C2, EMIT_C3: begin
                r_out_char <= CHAR_BIAS + {1'b0, field};
                r_out_end  <= 1'b0;
            end
            EMIT_NL: begin
                r_out_char <= NEWLINE_CHAR;
                r_out_end  <= 1'b1;
            end
            default: begin
                r_out_char <= r_out_char;
                r_out_end  <= r_out_end;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_line_end  = r_out_end;

endmodule
